>>> design/pidw_pkg.sv
// Package for the process id watch table.
// Holds the command codes, the transaction payload structs and the table control structs.
// No dependencies.
package pidw_pkg;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned PID_W = 32;

  localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_CHILD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] parent_pid;
    logic             pid_known;
    logic             rights_write;
    logic             clear_right_flag;
  } in_t;

  typedef struct packed {
    logic decided;
    logic block;
    logic rights_write_out;
    logic found;
    logic inserted;
    logic dropped;
  } out_t;

  // table update requests from the command decoder
  typedef struct packed {
    logic ins;
    logic rm;
    logic clr;
  } tbl_ctrl_t;

  // lookup results from the table
  typedef struct packed {
    logic id_zero;
    logic id_hit;
    logic parent_hit;
    logic full;
  } tbl_stat_t;

endpackage

>>> design/pidw_table.sv
// Slot storage of the watch table: parallel compares, lowest free slot, updates.
// Depends on pidw_pkg.
module pidw_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ID_WIDTH-1:0]   id,
  input  logic [ID_WIDTH-1:0]   parent_id,
  input  pidw_pkg::tbl_ctrl_t   ctrl,
  output pidw_pkg::tbl_stat_t   stat
);

  logic [ID_WIDTH-1:0]    slots_r   [TABLE_DEPTH];
  logic [ID_WIDTH-1:0]    slots_nxt [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] id_match;
  logic [TABLE_DEPTH-1:0] parent_match;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic [TABLE_DEPTH-1:0] first_free;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      id_match[i]     = (slots_r[i] == id);
      parent_match[i] = (slots_r[i] == parent_id);
      free_vec[i]     = (slots_r[i] == '0);
    end
  end

  // isolate lowest set bit
  assign first_free = free_vec & (~free_vec + TABLE_DEPTH'(1));

  assign stat.id_zero    = (id == '0);
  assign stat.id_hit     = (id != '0) && (|id_match);
  assign stat.parent_hit = (parent_id != '0) && (|parent_match);
  assign stat.full       = ~(|free_vec);

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slots_nxt[i] = slots_r[i];
      if (ctrl.clr) begin
        slots_nxt[i] = '0;
      end else if (ctrl.rm && id_match[i]) begin
        slots_nxt[i] = '0;
      end else if (ctrl.ins && first_free[i]) begin
        slots_nxt[i] = id;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!rst_n) begin
        slots_r[i] <= '0;
      end else begin
        slots_r[i] <= slots_nxt[i];
      end
    end
  end

endmodule

>>> design/pidw_cmd.sv
// Command decoder of the watch table: turns a registered transaction and the table
// lookups into table updates and the result. Depends on pidw_pkg.
module pidw_cmd (
  input  logic                valid,
  input  pidw_pkg::in_t       item,
  input  pidw_pkg::tbl_stat_t stat,
  output pidw_pkg::tbl_ctrl_t ctrl,
  output pidw_pkg::out_t      res
);

  logic add_ok;

  always_comb begin
    ctrl                 = '0;
    res                  = '0;
    res.rights_write_out = item.rights_write;
    add_ok               = 1'b0;
    case (item.cmd)
      pidw_pkg::CMD_ADD, pidw_pkg::CMD_ADD_CHILD: begin
        if (item.cmd == pidw_pkg::CMD_ADD_CHILD) begin
          res.found = stat.parent_hit;
        end
        add_ok       = ((item.cmd == pidw_pkg::CMD_ADD) || stat.parent_hit) && !stat.id_zero;
        ctrl.ins     = valid && add_ok;
        res.inserted = add_ok && !stat.full;
        res.dropped  = add_ok && stat.full;
      end
      pidw_pkg::CMD_REMOVE: begin
        ctrl.rm   = valid && !stat.id_zero;
        res.found = stat.id_hit;
      end
      pidw_pkg::CMD_CLASSIFY: begin
        res.found = item.pid_known && stat.id_hit;
        if (item.rights_write) begin
          res.decided = 1'b1;
          res.block   = res.found;
          if (res.found || item.clear_right_flag) begin
            res.rights_write_out = 1'b0;
          end
        end
      end
      pidw_pkg::CMD_CLEAR: begin
        ctrl.clr = valid;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/process_id_watch_table.sv
// Process id watch table, top level.
// Depends on pidw_pkg, pidw_table and pidw_cmd.
//
// Input channel: a transaction is taken at a rising edge with start high and busy
// low. busy stays low, so one command can be issued every cycle.
// The command is registered, then looked up against all slots in parallel
// (equality compares plus a priority pick of the lowest free slot) and the
// table and the result register update on the next edge.
// Result channel: out_valid is high for exactly one cycle with out_data, once the
// command has passed valid_r and out_valid_r; one result per command, in order.
// Back-to-back commands see each other's table updates, since the table is
// written on the same edge that loads the next command into the stage.
// Throughput: one command per cycle, set by the single compare pass over the slots.
// The receiver cannot stall; results are not held.
// Reset (synchronous, rst_n low) empties every slot and drops any command in flight.
module process_id_watch_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pidw_pkg::in_t  in_data,
  output logic           out_valid,
  output pidw_pkg::out_t out_data
);

  localparam int unsigned UW = (ID_WIDTH < pidw_pkg::PID_W) ? ID_WIDTH : pidw_pkg::PID_W;

  logic                valid_r;
  pidw_pkg::in_t       item_r;
  logic                out_valid_r;
  pidw_pkg::out_t      out_data_r;
  logic [ID_WIDTH-1:0] id;
  logic [ID_WIDTH-1:0] parent_id;
  pidw_pkg::tbl_ctrl_t ctrl;
  pidw_pkg::tbl_stat_t stat;
  pidw_pkg::out_t      res;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // only the low ID_WIDTH bits of an id take part
  always_comb begin
    id                = '0;
    parent_id         = '0;
    id[UW-1:0]        = item_r.pid[UW-1:0];
    parent_id[UW-1:0] = item_r.parent_pid[UW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= accept;
      out_valid_r <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (valid_r) begin
      out_data_r <= res;
    end
  end

  pidw_cmd u_cmd (
    .valid (valid_r),
    .item  (item_r),
    .stat  (stat),
    .ctrl  (ctrl),
    .res   (res)
  );

  pidw_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .id        (id),
    .parent_id (parent_id),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/pidw_checker.sv
// Port-level checker for the process id watch table, bound to the top level.
// Depends on pidw_pkg.
module pidw_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input pidw_pkg::out_t out_data
);

  // every result traces back to an earlier accepted transaction
  a_res_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a command");

  a_cmd_gives_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("command lost");

  a_block_needs_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.block) |-> (out_data.decided && !out_data.rights_write_out))
    else $error("block without decision or with write right kept");

  a_ins_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.inserted && out_data.dropped))
    else $error("inserted and dropped together");

endmodule

bind process_id_watch_table pidw_checker u_pidw_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for process_id_watch_table: directed table, then random command phases.
// Depends on pidw_pkg and the process_id_watch_table RTL;
// results are checked against a local table model or a directed row's typed verdict.
module testbench;

  localparam int DEPTH       = 16;
  localparam int ITEMS       = 550;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_SHOWN   = 10;
  localparam int POOL_N      = 10;

  // codes the block decodes as no-ops
  localparam logic [pidw_pkg::CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [pidw_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [pidw_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  localparam logic [pidw_pkg::PID_W-1:0] PID_MAX = '1;

  typedef struct {
    pidw_pkg::in_t  stim;
    bit             typed;
    pidw_pkg::out_t want;
  } dir_row_t;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  logic           out_valid;
  pidw_pkg::in_t  in_data;
  pidw_pkg::out_t out_data;

  logic [pidw_pkg::PID_W-1:0] model_slots [DEPTH];
  logic [pidw_pkg::PID_W-1:0] id_pool [POOL_N];
  pidw_pkg::out_t             pending_verdicts [$];
  dir_row_t                   dir_tab [$];
  int                         mismatches   = 0;
  int                         sent         = 0;
  int                         burst_left   = 0;
  int                         stall_cycles = 0;

  process_id_watch_table u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- table model ----------------

  function automatic bit id_watched(logic [pidw_pkg::PID_W-1:0] id);
    if (id == '0) return 1'b0;
    foreach (model_slots[i]) if (model_slots[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  // applies one command to the model table and returns the verdict it yields
  function automatic pidw_pkg::out_t apply_cmd(pidw_pkg::in_t c);
    pidw_pkg::out_t r;
    r = '0;
    r.rights_write_out = c.rights_write;
    case (c.cmd)
      pidw_pkg::CMD_ADD, pidw_pkg::CMD_ADD_CHILD: begin
        if (c.cmd == pidw_pkg::CMD_ADD_CHILD) r.found = id_watched(c.parent_pid);
        if ((c.cmd == pidw_pkg::CMD_ADD || r.found) && c.pid != '0) begin
          r.dropped = 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            if (model_slots[i] == '0) begin
              model_slots[i] = c.pid;
              r.inserted = 1'b1;
              r.dropped = 1'b0;
              break;
            end
          end
        end
      end
      pidw_pkg::CMD_REMOVE: begin
        if (c.pid != '0) begin
          foreach (model_slots[i]) begin
            if (model_slots[i] == c.pid) begin
              model_slots[i] = '0;
              r.found = 1'b1;
            end
          end
        end
      end
      pidw_pkg::CMD_CLASSIFY: begin
        r.found = c.pid_known && id_watched(c.pid);
        if (c.rights_write) begin
          r.decided = 1'b1;
          r.block = r.found;
          if (r.found || c.clear_right_flag) r.rights_write_out = 1'b0;
        end
      end
      pidw_pkg::CMD_CLEAR: begin
        foreach (model_slots[i]) model_slots[i] = '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic pidw_pkg::in_t mk(logic [pidw_pkg::CMD_W-1:0] c,
                                       logic [pidw_pkg::PID_W-1:0] p,
                                       logic [pidw_pkg::PID_W-1:0] pp,
                                       logic k, logic rw, logic cl);
    pidw_pkg::in_t t;
    t.cmd = c;
    t.pid = p;
    t.parent_pid = pp;
    t.pid_known = k;
    t.rights_write = rw;
    t.clear_right_flag = cl;
    return t;
  endfunction

  function automatic void add_row(pidw_pkg::in_t s, bit typed, logic [5:0] want);
    dir_row_t row;
    row.stim = s;
    row.typed = typed;
    row.want = want;
    dir_tab.push_back(row);
  endfunction

  function automatic logic [pidw_pkg::PID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return id_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  function automatic logic [pidw_pkg::PID_W-1:0] pick_nz();
    logic [pidw_pkg::PID_W-1:0] id;
    id = pick_id();
    return (id == '0) ? id_pool[$urandom_range(0, POOL_N - 1)] : id;
  endfunction

  function automatic pidw_pkg::in_t rand_flags(logic [pidw_pkg::CMD_W-1:0] c,
                                               logic [pidw_pkg::PID_W-1:0] p,
                                               logic [pidw_pkg::PID_W-1:0] pp);
    return mk(c, p, pp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [pidw_pkg::CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return pidw_pkg::CMD_ADD;
    if (r < 45) return pidw_pkg::CMD_ADD_CHILD;
    if (r < 60) return pidw_pkg::CMD_REMOVE;
    if (r < 92) return pidw_pkg::CMD_CLASSIFY;
    if (r < 96) return pidw_pkg::CMD_CLEAR;
    return CMD_RSVD_5 + pidw_pkg::CMD_W'($urandom_range(0, 2));
  endfunction

  // one transaction; the verdict is predicted at the accepting edge
  task automatic send(pidw_pkg::in_t s, bit typed = 1'b0, pidw_pkg::out_t want = '0);
    pidw_pkg::out_t pred;
    @(negedge clk);
    start <= 1'b1;
    in_data <= s;
    do begin
      @(posedge clk);
    end while (busy);
    pred = apply_cmd(s);
    pending_verdicts.push_back(typed ? want : pred);
    sent++;
  endtask

  // sender bursts: random gap, then a burst of random length
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 10);
    repeat (gap) @(negedge clk) start <= 1'b0;
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // clear, then add DEPTH to DEPTH+4 ids so that adds get dropped
  task automatic fill_phase();
    int n;
    n = $urandom_range(DEPTH, DEPTH + 4);
    pace();
    send(rand_flags(pidw_pkg::CMD_CLEAR, pick_id(), pick_id()));
    repeat (n) begin
      pace();
      send(rand_flags(pidw_pkg::CMD_ADD, pick_nz(), pick_id()));
    end
    repeat ($urandom_range(2, 6)) begin
      pace();
      send(rand_flags(($urandom_range(0, 1) != 0) ? pidw_pkg::CMD_ADD_CHILD
                                                  : pidw_pkg::CMD_CLASSIFY,
                      pick_id(), pick_nz()));
    end
  endtask

  // each child names the previous id as its parent, but one in five gets a random parent
  task automatic chain_phase();
    logic [pidw_pkg::PID_W-1:0] prev;
    logic [pidw_pkg::PID_W-1:0] child;
    prev = pick_nz();
    pace();
    send(rand_flags(pidw_pkg::CMD_ADD, prev, pick_id()));
    repeat ($urandom_range(3, 8)) begin
      child = pick_nz();
      pace();
      send(rand_flags(pidw_pkg::CMD_ADD_CHILD, child,
                      ($urandom_range(0, 4) == 0) ? pick_id() : prev));
      prev = child;
    end
    repeat ($urandom_range(2, 5)) begin
      pace();
      send(rand_flags(($urandom_range(0, 3) == 0) ? pidw_pkg::CMD_REMOVE
                                                  : pidw_pkg::CMD_CLASSIFY,
                      ($urandom_range(0, 1) != 0) ? prev : pick_id(), pick_id()));
    end
  endtask

  task automatic mixed_phase(int n);
    repeat (n) begin
      pace();
      send(rand_flags(pick_cmd(), pick_id(), pick_id()));
    end
  endtask

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%0t: %s", $time, what);
  endtask

  // ---------------- result checking and watchdog ----------------

  always @(posedge clk) begin : result_check
    pidw_pkg::out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_verdicts.size() == 0) begin
          note_mismatch($sformatf("result with no transaction pending: %b", out_data));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_data.decided !== want.decided || out_data.block !== want.block ||
              out_data.rights_write_out !== want.rights_write_out ||
              out_data.found !== want.found || out_data.inserted !== want.inserted ||
              out_data.dropped !== want.dropped)
            note_mismatch($sformatf(
              "decided/block/rw_out/found/inserted/dropped exp %b%b%b%b%b%b got %b%b%b%b%b%b",
              want.decided, want.block, want.rights_write_out, want.found,
              want.inserted, want.dropped,
              out_data.decided, out_data.block, out_data.rights_write_out,
              out_data.found, out_data.inserted, out_data.dropped));
        end
      end
      if (out_valid || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("process_id_watch_table test failed");
        $finish;
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    foreach (model_slots[i]) model_slots[i] = '0;

    id_pool[0] = PID_MAX;
    id_pool[1] = 32'h0000_0001;
    id_pool[2] = 32'h8000_0000;
    for (int i = 3; i < POOL_N; i++) id_pool[i] = $urandom | 32'h1;

    // verdict bits: decided, block, rights_write_out, found, inserted, dropped
    add_row(mk(pidw_pkg::CMD_CLASSIFY,  PID_MAX, '0,      1, 1, 0), 1, 6'b101000); // empty
    add_row(mk(CMD_RSVD_5,              PID_MAX, PID_MAX, 1, 1, 1), 1, 6'b001000);
    add_row(mk(CMD_RSVD_7,              '0,      '0,      0, 0, 0), 1, 6'b000000);
    add_row(mk(pidw_pkg::CMD_ADD,       '0,      PID_MAX, 1, 1, 1), 1, 6'b001000); // zero id
    add_row(mk(pidw_pkg::CMD_ADD,       PID_MAX, '0,      0, 0, 0), 1, 6'b000010);
    add_row(mk(pidw_pkg::CMD_CLASSIFY,  PID_MAX, '0,      1, 1, 0), 1, 6'b110100); // block
    add_row(mk(pidw_pkg::CMD_CLASSIFY,  PID_MAX, '0,      0, 1, 1), 1, 6'b100000); // permit
    add_row(mk(pidw_pkg::CMD_CLASSIFY,  PID_MAX, '0,      0, 1, 0), 0, '0);
    add_row(mk(pidw_pkg::CMD_CLASSIFY,  PID_MAX, '0,      1, 0, 1), 0, '0); // undecided
    add_row(mk(pidw_pkg::CMD_ADD_CHILD, 32'h1,   PID_MAX, 0, 0, 0), 0, '0);
    add_row(mk(pidw_pkg::CMD_ADD_CHILD, 32'h2,   32'h3,   1, 1, 0), 0, '0); // parent absent
    add_row(mk(pidw_pkg::CMD_ADD_CHILD, 32'h5,   '0,      0, 1, 1), 0, '0); // zero parent
    add_row(mk(pidw_pkg::CMD_ADD_CHILD, '0,      PID_MAX, 1, 0, 0), 0, '0); // zero child
    add_row(mk(pidw_pkg::CMD_ADD,       PID_MAX, PID_MAX, 1, 1, 1), 0, '0); // duplicate
    add_row(mk(pidw_pkg::CMD_REMOVE,    PID_MAX, '0,      0, 0, 0), 0, '0); // both copies
    add_row(mk(pidw_pkg::CMD_CLASSIFY,  PID_MAX, '0,      1, 1, 0), 0, '0);
    add_row(mk(pidw_pkg::CMD_REMOVE,    '0,      PID_MAX, 1, 1, 1), 0, '0);
    add_row(mk(pidw_pkg::CMD_CLASSIFY,  '0,      '0,      1, 1, 1), 0, '0); // zero id
    add_row(mk(pidw_pkg::CMD_REMOVE,    32'h1,   '0,      0, 1, 0), 0, '0);
    add_row(mk(pidw_pkg::CMD_ADD_CHILD, 32'h7,   32'h1,   0, 0, 0), 0, '0);
    add_row(mk(CMD_RSVD_6,              PID_MAX, '0,      0, 1, 0), 1, 6'b001000);
    add_row(mk(pidw_pkg::CMD_ADD,       32'h9,   '0,      0, 0, 0), 0, '0);
    add_row(mk(pidw_pkg::CMD_CLEAR,     PID_MAX, PID_MAX, 1, 1, 1), 1, 6'b001000);
    add_row(mk(pidw_pkg::CMD_CLASSIFY,  32'h9,   '0,      1, 1, 0), 0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      pace();
      send(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
    end

    // hold off until the table has answered everything
    drain();
    fill_phase();
    while (sent < ITEMS) begin
      case ($urandom_range(0, 5))
        0:       fill_phase();
        1:       chain_phase();
        default: mixed_phase($urandom_range(20, 40));
      endcase
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("process_id_watch_table test passed");
    end else begin
      $display("process_id_watch_table test failed");
    end
    $finish;
  end

endmodule
